// ===== rtl/pf_pkg.sv =====
// ----------------------------------------------------------------------------
// pf_pkg - shared types for the playfair digraph encryptor
// Letter codes, request and result payloads, queue commands, back-end states
// and small helpers for square coordinates.
// ----------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

    localparam int NUM_LETTERS = 26;
    localparam int SQ_SIDE     = 5;
    localparam int SQ_CELLS    = 25;

    typedef logic [4:0] letter_t;
    typedef logic [2:0] coord_t;
    typedef logic [4:0] cell_t;

    localparam letter_t LETTER_I    = 5'd8;
    localparam letter_t LETTER_J    = 5'd9;
    localparam letter_t LETTER_X    = 5'd23;
    localparam letter_t LAST_LETTER = 5'd25;
    localparam coord_t  LAST_COORD  = 3'd4;
    localparam cell_t   FULL_COUNT  = 5'd25;

    // request opcodes
    typedef enum logic [1:0] {
        OP_KEY    = 2'd0,
        OP_FINISH = 2'd1,
        OP_PLAIN  = 2'd2,
        OP_END    = 2'd3
    } op_t;

    typedef struct packed {
        op_t     opcode;
        letter_t letter;
    } pf_in_t;

    typedef struct packed {
        letter_t cipher_first;
        letter_t cipher_second;
    } pf_out_t;

    // commands from the front end to the back end
    typedef enum logic [1:0] {
        CMD_PLACE = 2'd0,
        CMD_FILL  = 2'd1,
        CMD_ENC   = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        letter_t   a;
        letter_t   b;
    } pf_cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_FILL = 2'd1,
        BK_POS  = 2'd2,
        BK_CELL = 2'd3
    } bk_state_t;

    // I and J share a cell
    function automatic letter_t fold_j(input letter_t v);
        return (v == LETTER_J) ? LETTER_I : v;
    endfunction

    // row * 5 + col
    function automatic cell_t cell_index(input coord_t row, input coord_t col);
        return cell_t'({row, 2'b00}) + cell_t'(row) + cell_t'(col);
    endfunction

    // step one place along a row or column, wrapping
    function automatic coord_t next_coord(input coord_t c);
        return (c == LAST_COORD) ? 3'd0 : c + 3'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/pf_front.sv =====
// ----------------------------------------------------------------------------
// pf_front - request decode and digraph pairing
// Holds the filler register and the pending first letter, and turns each
// accepted request into at most one command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_front
    import pf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire pf_in_t  item,
    input  wire logic    cfg_we,
    input  wire letter_t cfg_data,
    output logic         push_valid,
    input  wire logic    push_ready,
    output pf_cmd_t      push_cmd
);

    letter_t filler_reg;
    logic    pend_valid_reg, pend_valid_next;
    letter_t pend_letter_reg, pend_letter_next;

    logic    accept;
    logic    in_range;
    letter_t v;
    letter_t eff_filler;

    assign item_ready = push_ready;
    assign accept     = item_valid & push_ready;
    assign in_range   = (item.letter <= LAST_LETTER);
    assign v          = fold_j(item.letter);

    // out-of-range filler falls back to X
    assign eff_filler = fold_j((filler_reg > LAST_LETTER) ? LETTER_X : filler_reg);

    // filler register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filler_reg <= LETTER_X;
        end
        else if (cfg_we)
        begin
            filler_reg <= cfg_data;
        end
    end

    // pending letter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg  <= 1'b0;
            pend_letter_reg <= '0;
        end
        else
        begin
            pend_valid_reg  <= pend_valid_next;
            pend_letter_reg <= pend_letter_next;
        end
    end

    // request decode
    always_comb
    begin
        push_valid       = 1'b0;
        push_cmd.kind    = CMD_PLACE;
        push_cmd.a       = v;
        push_cmd.b       = v;
        pend_valid_next  = pend_valid_reg;
        pend_letter_next = pend_letter_reg;
        if (accept)
        begin
            case (item.opcode)
                OP_KEY:
                begin
                    push_valid = in_range;
                end
                OP_FINISH:
                begin
                    push_valid    = 1'b1;
                    push_cmd.kind = CMD_FILL;
                end
                OP_PLAIN:
                begin
                    if (in_range)
                    begin
                        if (!pend_valid_reg)
                        begin
                            pend_valid_next  = 1'b1;
                            pend_letter_next = v;
                        end
                        else if (pend_letter_reg == v)
                        begin
                            // doubled letter: split with filler, keep second held
                            push_valid    = 1'b1;
                            push_cmd.kind = CMD_ENC;
                            push_cmd.a    = pend_letter_reg;
                            push_cmd.b    = eff_filler;
                        end
                        else
                        begin
                            push_valid       = 1'b1;
                            push_cmd.kind    = CMD_ENC;
                            push_cmd.a       = pend_letter_reg;
                            push_cmd.b       = v;
                            pend_valid_next  = 1'b0;
                            pend_letter_next = '0;
                        end
                    end
                end
                OP_END:
                begin
                    if (pend_valid_reg)
                    begin
                        push_valid       = 1'b1;
                        push_cmd.kind    = CMD_ENC;
                        push_cmd.a       = pend_letter_reg;
                        push_cmd.b       = eff_filler;
                        pend_valid_next  = 1'b0;
                        pend_letter_next = '0;
                    end
                end
                default:
                begin
                    push_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pf_queue.sv =====
// ----------------------------------------------------------------------------
// pf_queue - command queue between front and back end
// Small circular buffer; full and empty come from an occupancy count.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_queue
    import pf_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push_valid,
    output logic         push_ready,
    input  wire pf_cmd_t push_cmd,
    output logic         pop_valid,
    input  wire logic    pop_ready,
    output pf_cmd_t      pop_cmd
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    pf_cmd_t          buf_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = buf_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            buf_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pf_back.sv =====
// ----------------------------------------------------------------------------
// pf_back - key square and digraph encryption
// Builds the square from place and fill commands and encrypts pairs through
// a position lookup, a cell lookup and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_back
    import pf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    pop_valid,
    output logic         pop_ready,
    input  wire pf_cmd_t pop_cmd,
    output logic         result_valid,
    input  wire logic    result_ready,
    output pf_out_t      result
);

    bk_state_t state_reg, state_next;

    // square build state
    logic [NUM_LETTERS-1:0] used_reg;
    cell_t                  fill_cnt_reg;
    coord_t                 fill_row_reg, fill_col_reg;
    letter_t                walk_reg, walk_next;

    // memories: cell -> letter, letter -> {row, col}
    letter_t      sq_mem  [SQ_CELLS];
    logic [5:0]   pos_mem [NUM_LETTERS];

    logic [5:0]   pa_reg, pb_reg;
    letter_t      x_reg, y_reg;
    logic         out_valid_reg;
    pf_out_t      out_data_reg;

    logic         place_req, place_do;
    letter_t      place_letter;
    logic         pos_rd_en, sq_rd_en, out_load;
    coord_t       ra, ca, rb, cb;
    coord_t       xr, xc, yr, yc;

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

    assign place_do = place_req && !used_reg[place_letter] && (fill_cnt_reg != FULL_COUNT);

    // sequencer
    always_comb
    begin
        state_next   = state_reg;
        walk_next    = walk_reg;
        pop_ready    = 1'b0;
        place_req    = 1'b0;
        place_letter = pop_cmd.a;
        pos_rd_en    = 1'b0;
        sq_rd_en     = 1'b0;
        out_load     = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    case (pop_cmd.kind)
                        CMD_PLACE:
                        begin
                            place_req = 1'b1;
                        end
                        CMD_FILL:
                        begin
                            walk_next  = '0;
                            state_next = BK_FILL;
                        end
                        CMD_ENC:
                        begin
                            pos_rd_en  = 1'b1;
                            state_next = BK_POS;
                        end
                        default:
                        begin
                            state_next = BK_IDLE;
                        end
                    endcase
                end
            end
            BK_FILL:
            begin
                // alphabetical walk, J skipped
                place_letter = walk_reg;
                place_req    = (walk_reg != LETTER_J);
                if (walk_reg == LAST_LETTER)
                begin
                    state_next = BK_IDLE;
                end
                else
                begin
                    walk_next = walk_reg + 5'd1;
                end
            end
            BK_POS:
            begin
                sq_rd_en   = 1'b1;
                state_next = BK_CELL;
            end
            BK_CELL:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_load   = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // playfair rules on the looked-up coordinates
    always_comb
    begin
        ra = pa_reg[5:3];
        ca = pa_reg[2:0];
        rb = pb_reg[5:3];
        cb = pb_reg[2:0];
        if (ra == rb)
        begin
            xr = ra;
            xc = next_coord(ca);
            yr = rb;
            yc = next_coord(cb);
        end
        else if (ca == cb)
        begin
            xr = next_coord(ra);
            xc = ca;
            yr = next_coord(rb);
            yc = cb;
        end
        else
        begin
            xr = ra;
            xc = cb;
            yr = rb;
            yc = ca;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            walk_reg      <= '0;
            used_reg      <= '0;
            fill_cnt_reg  <= '0;
            fill_row_reg  <= '0;
            fill_col_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            if (place_do)
            begin
                used_reg[place_letter] <= 1'b1;
                fill_cnt_reg           <= fill_cnt_reg + 5'd1;
                if (fill_col_reg == LAST_COORD)
                begin
                    fill_col_reg <= '0;
                    fill_row_reg <= fill_row_reg + 3'd1;
                end
                else
                begin
                    fill_col_reg <= fill_col_reg + 3'd1;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // memory writes
    always_ff @(posedge clk)
    begin
        if (place_do)
        begin
            sq_mem[fill_cnt_reg]  <= place_letter;
            pos_mem[place_letter] <= {fill_row_reg, fill_col_reg};
        end
    end

    // position lookup
    always_ff @(posedge clk)
    begin
        if (pos_rd_en)
        begin
            pa_reg <= pos_mem[pop_cmd.a];
            pb_reg <= pos_mem[pop_cmd.b];
        end
    end

    // cell lookup
    always_ff @(posedge clk)
    begin
        if (sq_rd_en)
        begin
            x_reg <= sq_mem[cell_index(xr, xc)];
            y_reg <= sq_mem[cell_index(yr, yc)];
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg.cipher_first  <= x_reg;
            out_data_reg.cipher_second <= y_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/playfair_digraph_encrypt.sv =====
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt - playfair cipher, one digraph per result
// Front end pairs letters and queues commands; back end builds the key
// square and encrypts each pair.
// ----------------------------------------------------------------------------
//  channel   signals                              payload
//  request   item_valid / item_ready              item (opcode, letter)
//  result    result_valid / result_ready          result (cipher_first/second)
//  config    cfg_we                               cfg_data (filler letter)
//
//  requests are taken one per cycle while the command queue has room
//  key letter: placed when popped; pair: pop with position read, cell read,
//  output load, in that order
//  finish key: the pop, then one alphabet letter per cycle
//  reset clears the fill state, pending letter and queue; a stalled result
//  holds the back end in its last step and the queue takes requests until full
// ----------------------------------------------------------------------------
`default_nettype none

module playfair_digraph_encrypt
    import pf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire pf_in_t  item,
    output logic         result_valid,
    input  wire logic    result_ready,
    output pf_out_t      result,
    input  wire logic    cfg_we,
    input  wire letter_t cfg_data
);

    logic    push_valid, push_ready;
    pf_cmd_t push_cmd;
    logic    pop_valid, pop_ready;
    pf_cmd_t pop_cmd;

    // decode and pairing
    pf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    // command queue
    pf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // square and encryption
    pf_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== rtl/pf_checker.sv =====
// ----------------------------------------------------------------------------
// pf_checker - port-level assertions for the playfair encryptor
// Watches the result channel against reset and against the requests that
// can produce a result.
// ----------------------------------------------------------------------------
`default_nettype none

module pf_checker
    import pf_pkg::*;
(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    item_valid,
    input wire logic    item_ready,
    input wire pf_in_t  item,
    input wire logic    result_valid,
    input wire logic    result_ready,
    input wire pf_out_t result
);

    logic [15:0] credit_reg;
    logic        lost_reg;
    logic        inc, dec;

    // plaintext and end requests are the only ones that can yield a result
    assign inc = item_valid && item_ready &&
                 (item.opcode == OP_PLAIN || item.opcode == OP_END);
    assign dec = result_valid && result_ready;

    // outstanding result credit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
            lost_reg   <= 1'b0;
        end
        else if (inc && !dec)
        begin
            if (credit_reg == 16'hFFFF)
            begin
                lost_reg <= 1'b1;
            end
            else
            begin
                credit_reg <= credit_reg + 16'd1;
            end
        end
        else if (dec && !inc && credit_reg != '0)
        begin
            credit_reg <= credit_reg - 16'd1;
        end
    end

    // stalled result holds
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // no result right out of reset
    a_reset_quiet: assert property (@(posedge clk)
        !$past(rst_n) |-> !result_valid)
        else $error("result valid right after reset");

    // every result is backed by a plaintext or end request
    a_result_backed: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (lost_reg || credit_reg != '0))
        else $error("result without a request that could cause it");

endmodule

bind playfair_digraph_encrypt pf_checker u_pf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// playfair_digraph_encrypt regression bench
// Builds one key square from a fixed key, then walks a directed table of
// requests followed by random plaintext over several filler settings. Every
// accepted request steps a local playfair predictor; each digraph the block
// returns is checked field by field against the oldest predicted digraph.
// ----------------------------------------------------------------------------

module testbench;
    import pf_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int IDLE_LIMIT    = 1000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 135;

    // letters used by the directed table
    localparam letter_t LT_A = 5'd0;
    localparam letter_t LT_B = 5'd1;
    localparam letter_t LT_D = 5'd3;
    localparam letter_t LT_E = 5'd4;
    localparam letter_t LT_F = 5'd5;
    localparam letter_t LT_H = 5'd7;
    localparam letter_t LT_L = 5'd11;
    localparam letter_t LT_M = 5'd12;
    localparam letter_t LT_P = 5'd15;
    localparam letter_t LT_R = 5'd17;
    localparam letter_t LT_Y = 5'd24;
    localparam letter_t LT_TOP = 5'd31;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_MODEL = 2'd0,
        CHK_NONE  = 2'd1,
        CHK_TYPED = 2'd2
    } check_t;

    typedef struct packed {
        op_t     opcode;
        letter_t letter;
        check_t  check;
        letter_t first;
        letter_t second;
    } plan_row_t;

    // key "playfair example" with J for I, then pairs that hit every rule
    localparam int PLAN_LEN = 26;
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        '{OP_KEY,    LT_P,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_L,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_Y,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_F,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LETTER_J,  CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_R,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_E,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LETTER_X,  CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_TOP,    CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_M,      CHK_NONE,  LT_A, LT_A},
        '{OP_FINISH, LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_KEY,    LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_FINISH, LT_TOP,    CHK_NONE,  LT_A, LT_A},
        '{OP_END,    LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LT_H,      CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LETTER_I,  CHK_TYPED, LT_B, LT_M},
        '{OP_PLAIN,  5'd30,     CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LT_A,      CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LT_D,      CHK_MODEL, LT_A, LT_A},
        '{OP_PLAIN,  LT_P,      CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LT_F,      CHK_MODEL, LT_A, LT_A},
        '{OP_PLAIN,  LETTER_X,  CHK_NONE,  LT_A, LT_A},
        '{OP_PLAIN,  LETTER_X,  CHK_MODEL, LT_A, LT_A},
        '{OP_END,    LT_TOP,    CHK_MODEL, LT_A, LT_A}
    };

    // filler settings for the first random phases, extremes first
    localparam int SWEEP_LEN = 5;
    localparam letter_t FILLER_SWEEP [SWEEP_LEN] = '{
        5'd0, LAST_LETTER, LT_TOP, LETTER_J, 5'd26
    };

    logic    clk = 1'b0;
    logic    rst_n;
    logic    item_valid;
    logic    item_ready;
    pf_in_t  item;
    logic    result_valid;
    logic    result_ready = 1'b0;
    pf_out_t result;
    logic    cfg_we;
    letter_t cfg_data;

    // predictor state
    letter_t square_cell [SQ_CELLS];
    int      square_pos  [NUM_LETTERS];
    bit      square_has  [NUM_LETTERS];
    int      square_count;
    bit      held_valid;
    letter_t held_letter;
    letter_t filler_reg;

    pf_out_t digraphs_due [$];

    int requests_sent;
    int digraphs_checked;
    int filler_settings;
    int error_count;
    int idle_cycles;
    int tx_calm;
    int rx_calm;
    int rx_stall;

    playfair_digraph_encrypt uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // idle length: mostly none or short, now and then long, with calm stretches
    function automatic int draw_gap(inout int calm_left);
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 39) == 0)
        begin
            calm_left = $urandom_range(20, 80);
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // append a letter to the square unless already placed or full
    function automatic void place_in_square(input letter_t v);
        if (!square_has[v] && square_count < SQ_CELLS)
        begin
            square_cell[square_count] = v;
            square_pos[v] = square_count;
            square_has[v] = 1'b1;
            square_count++;
        end
    endfunction

    // row, column and rectangle rules
    function automatic pf_out_t encipher_pair(input letter_t a, input letter_t b);
        int ra;
        int ca;
        int rb;
        int cb;
        pf_out_t c;
        ra = square_pos[a] / SQ_SIDE;
        ca = square_pos[a] % SQ_SIDE;
        rb = square_pos[b] / SQ_SIDE;
        cb = square_pos[b] % SQ_SIDE;
        if (ra == rb)
        begin
            c.cipher_first  = square_cell[ra * SQ_SIDE + (ca + 1) % SQ_SIDE];
            c.cipher_second = square_cell[rb * SQ_SIDE + (cb + 1) % SQ_SIDE];
        end
        else if (ca == cb)
        begin
            c.cipher_first  = square_cell[((ra + 1) % SQ_SIDE) * SQ_SIDE + ca];
            c.cipher_second = square_cell[((rb + 1) % SQ_SIDE) * SQ_SIDE + cb];
        end
        else
        begin
            c.cipher_first  = square_cell[ra * SQ_SIDE + cb];
            c.cipher_second = square_cell[rb * SQ_SIDE + ca];
        end
        return c;
    endfunction

    // advance the predictor by one accepted request
    task automatic step_playfair(input pf_in_t req, output bit produced,
                                 output pf_out_t cipher);
        letter_t v;
        letter_t f;
        produced = 1'b0;
        cipher   = '0;
        v = (req.letter == LETTER_J) ? LETTER_I : req.letter;
        f = (filler_reg > LAST_LETTER) ? LETTER_X : filler_reg;
        if (f == LETTER_J)
            f = LETTER_I;
        case (req.opcode)
            OP_KEY:
            begin
                if (req.letter <= LAST_LETTER)
                    place_in_square(v);
            end
            OP_FINISH:
            begin
                for (int k = 0; k < NUM_LETTERS; k++)
                    if (letter_t'(k) != LETTER_J)
                        place_in_square(letter_t'(k));
            end
            OP_PLAIN:
            begin
                if (req.letter <= LAST_LETTER)
                begin
                    if (!held_valid)
                    begin
                        held_valid  = 1'b1;
                        held_letter = v;
                    end
                    else if (held_letter == v)
                    begin
                        // doubled letter: split by filler, second stays held
                        cipher   = encipher_pair(held_letter, f);
                        produced = 1'b1;
                    end
                    else
                    begin
                        cipher      = encipher_pair(held_letter, v);
                        produced    = 1'b1;
                        held_valid  = 1'b0;
                        held_letter = '0;
                    end
                end
            end
            default:
            begin
                // end of message pads a held letter
                if (held_valid)
                begin
                    cipher      = encipher_pair(held_letter, f);
                    produced    = 1'b1;
                    held_valid  = 1'b0;
                    held_letter = '0;
                end
            end
        endcase
    endtask

    // present one request, wait for acceptance, then predict
    task automatic issue_request(input pf_in_t req, output bit produced,
                                 output pf_out_t cipher);
        int gap;
        gap = draw_gap(tx_calm);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= req;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        requests_sent++;
        step_playfair(req, produced, cipher);
    endtask

    // wait for all digraphs, then let the back end go quiet
    task automatic settle();
        item_valid <= 1'b0;
        while (digraphs_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_filler(input letter_t v);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we     <= 1'b0;
        filler_reg  = v;
        filler_settings++;
    endtask

    // result side: random stalls and digraph check
    always @(posedge clk)
    begin : result_side
        int g;
        pf_out_t want;
        if (rst_n)
        begin
            if (result_valid && result_ready)
            begin
                if (digraphs_due.size() == 0)
                begin
                    $error("digraph %0d/%0d returned with none outstanding",
                           result.cipher_first, result.cipher_second);
                    error_count++;
                end
                else
                begin
                    want = digraphs_due.pop_front();
                    digraphs_checked++;
                    if (result.cipher_first !== want.cipher_first)
                    begin
                        $error("cipher_first: expected %0d, actual %0d",
                               want.cipher_first, result.cipher_first);
                        error_count++;
                    end
                    if (result.cipher_second !== want.cipher_second)
                    begin
                        $error("cipher_second: expected %0d, actual %0d",
                               want.cipher_second, result.cipher_second);
                        error_count++;
                    end
                end
            end
            if (rx_stall > 0)
            begin
                rx_stall--;
                result_ready <= 1'b0;
            end
            else if (!result_ready || result_valid)
            begin
                g = draw_gap(rx_calm);
                if (g > 0)
                begin
                    result_ready <= 1'b0;
                    rx_stall = g - 1;
                end
                else
                    result_ready <= 1'b1;
            end
        end
    end

    // watchdog on handshake progress
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout after %0d cycles without a handshake", IDLE_LIMIT);
                $display("playfair_digraph_encrypt regression: fail");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        pf_in_t    req;
        plan_row_t row;
        pf_out_t   cipher;
        pf_out_t   typed;
        bit        produced;
        bit        counts;
        int        counted;
        int        pick;
        letter_t   last_plain;
        letter_t   fill;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_we     = 1'b0;
        cfg_data   = LETTER_X;
        for (int k = 0; k < NUM_LETTERS; k++)
        begin
            square_has[k] = 1'b0;
            square_pos[k] = 0;
        end
        for (int k = 0; k < SQ_CELLS; k++)
            square_cell[k] = '0;
        square_count     = 0;
        held_valid       = 1'b0;
        held_letter      = '0;
        filler_reg       = LETTER_X;
        requests_sent    = 0;
        digraphs_checked = 0;
        filler_settings  = 0;
        error_count      = 0;
        idle_cycles      = 0;
        tx_calm          = 0;
        rx_calm          = 0;
        rx_stall         = 0;
        last_plain       = LT_A;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        write_filler(LETTER_X);

        // directed table
        for (int i = 0; i < PLAN_LEN; i++)
        begin
            row        = DIRECTED_PLAN[i];
            req.opcode = row.opcode;
            req.letter = row.letter;
            issue_request(req, produced, cipher);
            if (row.check == CHK_MODEL && produced)
                digraphs_due.push_back(cipher);
            else if (row.check == CHK_TYPED)
            begin
                typed.cipher_first  = row.first;
                typed.cipher_second = row.second;
                digraphs_due.push_back(typed);
            end
        end
        settle();

        // random plaintext, one filler setting per phase
        for (int p = 0; p < PHASES; p++)
        begin
            if (p < SWEEP_LEN)
                write_filler(FILLER_SWEEP[p]);
            else
                write_filler(letter_t'($urandom_range(0, 31)));
            fill    = (filler_reg > LAST_LETTER) ? LETTER_X : filler_reg;
            counted = 0;
            while (counted < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 8)
                begin
                    // noise: key on a full square, finish again, bad letter
                    case ($urandom_range(0, 2))
                        0:
                        begin
                            req.opcode = OP_KEY;
                            req.letter = letter_t'($urandom_range(0, 31));
                        end
                        1:
                        begin
                            req.opcode = OP_FINISH;
                            req.letter = letter_t'($urandom_range(0, 31));
                        end
                        default:
                        begin
                            req.opcode = OP_PLAIN;
                            req.letter = letter_t'($urandom_range(26, 31));
                        end
                    endcase
                end
                else if (pick < 20)
                begin
                    req.opcode = OP_END;
                    req.letter = letter_t'($urandom_range(0, 31));
                end
                else
                begin
                    // plaintext, biased toward doubles, the filler and J
                    pick = $urandom_range(0, 99);
                    req.opcode = OP_PLAIN;
                    if (pick < 15)
                        req.letter = last_plain;
                    else if (pick < 22)
                        req.letter = fill;
                    else if (pick < 27)
                        req.letter = LETTER_J;
                    else
                        req.letter = letter_t'($urandom_range(0, 25));
                    last_plain = req.letter;
                end
                counts = (req.opcode == OP_PLAIN && req.letter <= LAST_LETTER)
                      || (req.opcode == OP_END && held_valid);
                issue_request(req, produced, cipher);
                if (produced)
                    digraphs_due.push_back(cipher);
                if (counts)
                    counted++;
            end
            settle();
        end

        if (digraphs_due.size() != 0)
        begin
            $error("%0d digraphs never returned", digraphs_due.size());
            error_count++;
        end
        $display("sent %0d requests: full key build, directed pairs and random plaintext",
                 requests_sent);
        $display("checked %0d digraphs over %0d filler settings, %0d mismatches",
                 digraphs_checked, filler_settings, error_count);
        if (error_count == 0)
            $display("playfair_digraph_encrypt regression: pass");
        else
            $display("playfair_digraph_encrypt regression: fail");
        $finish;
    end

endmodule
